>>> hdl/a64pue_pkg.sv
package a64pue_pkg;

	// Phases of one word's run, in emission order; the value is also the bit
	// position in the presence vector, which has no bit for PH_MAL
	localparam int unsigned NUM_PHASES = 9;

	typedef enum logic [3:0] {
		PH_SIGN   = 4'd0,
		PH_INT    = 4'd1,
		PH_LR     = 4'd2,
		PH_FP     = 4'd3,
		PH_HOME   = 4'd4,
		PH_ALLOC1 = 4'd5,
		PH_ALLOC2 = 4'd6,
		PH_FPLR   = 4'd7,
		PH_SETFP  = 4'd8,
		PH_MAL    = 4'd9
	} phase_t;

	// Operation kinds
	localparam logic [2:0] OP_SIGN_RA       = 3'd0;
	localparam logic [2:0] OP_SAVE_REG_PRE  = 3'd1;
	localparam logic [2:0] OP_SAVE_PAIR_PRE = 3'd2;
	localparam logic [2:0] OP_SAVE_REG      = 3'd3;
	localparam logic [2:0] OP_SAVE_PAIR     = 3'd4;
	localparam logic [2:0] OP_ALLOC         = 3'd5;
	localparam logic [2:0] OP_SET_FP        = 3'd6;
	localparam logic [2:0] OP_NONE          = 3'd7;

	// Register classes
	localparam logic CLASS_GP = 1'b0;
	localparam logic CLASS_FP = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PARTIAL   = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	// Flag codes of a packed word
	localparam logic [1:0] FLAG_PACKED      = 2'd1;
	localparam logic [1:0] FLAG_PACKED_FRAG = 2'd2;

	// CR codes
	localparam logic [1:0] CR_LR_SAVED   = 2'd1;
	localparam logic [1:0] CR_CHAIN_SIGN = 2'd2;
	localparam logic [1:0] CR_CHAIN      = 2'd3;

	// Register numbers
	localparam logic [5:0] REG_FIRST_INT = 6'd19;
	localparam logic [5:0] REG_FIRST_FP  = 6'd8;
	localparam logic [5:0] REG_FP        = 6'd29;
	localparam logic [5:0] REG_LR        = 6'd30;

	// Allocation limits
	localparam logic [12:0] MAX_SINGLE_ALLOC = 13'd4080;
	localparam logic [12:0] CHAIN_PAIR_LIMIT = 13'd512;

	// Controller to datapath
	typedef struct packed {
		logic   load;
		logic   emit;
		phase_t phase;
		logic   last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [NUM_PHASES-1:0] present;
		logic                  mal;
		logic                  done;
	} dp_stat_t;

endpackage

>>> hdl/a64pue_dp.sv
module a64pue_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         packed_word,
	input  a64pue_pkg::dp_cmd_t cmd,
	output a64pue_pkg::dp_stat_t stat,
	output logic [2:0]          op_kind,
	output logic                reg_class,
	output logic [5:0]          first_reg,
	output logic [5:0]          second_reg,
	output logic [12:0]         stack_offset,
	output logic [4:0]          op_index,
	output logic [1:0]          status,
	output logic                last
);

	// Word decode, ahead of the decode registers
	logic [1:0]  w_flag;
	logic [2:0]  w_regf;
	logic [3:0]  w_regi;
	logic        w_home;
	logic [1:0]  w_cr;
	logic [12:0] w_frame;
	logic [7:0]  d_int;
	logic [6:0]  d_fp;
	logic [8:0]  d_sum;
	logic [8:0]  d_saved;
	logic        d_mal;
	logic [12:0] d_local;

	assign w_flag  = packed_word[1:0];
	assign w_regf  = packed_word[15:13];
	assign w_regi  = packed_word[19:16];
	assign w_home  = packed_word[20];
	assign w_cr    = packed_word[22:21];
	assign w_frame = {packed_word[31:23], 4'b0000};

	always_comb begin
		d_int   = {1'b0, w_regi, 3'b000} + ((w_cr == a64pue_pkg::CR_LR_SAVED) ? 8'd8 : 8'd0);
		d_fp    = (w_regf != 3'd0) ? ({1'b0, w_regf, 3'b000} + 7'd8) : 7'd0;
		d_sum   = {1'b0, d_int} + {2'b00, d_fp} + (w_home ? 9'd64 : 9'd0) + 9'd15;
		d_saved = {d_sum[8:4], 4'b0000};
		d_mal   = !((w_flag == a64pue_pkg::FLAG_PACKED) ||
			(w_flag == a64pue_pkg::FLAG_PACKED_FRAG)) || ({4'b0000, d_saved} > w_frame);
		d_local = w_frame - {4'b0000, d_saved};
	end

	// Decode registers
	logic [2:0]  regf_q;
	logic [3:0]  regi_q;
	logic        home_q;
	logic [1:0]  cr_q;
	logic [7:0]  int_bytes_q;
	logic [6:0]  fp_bytes_q;
	logic [8:0]  saved_q;
	logic [12:0] local_q;
	logic        mal_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			regf_q      <= w_regf;
			regi_q      <= w_regi;
			home_q      <= w_home;
			cr_q        <= w_cr;
			int_bytes_q <= d_int;
			fp_bytes_q  <= d_fp;
			saved_q     <= d_saved;
			local_q     <= d_local;
			mal_q       <= d_mal;
		end
	end

	// Which phases this word produces
	logic chain;
	logic lr_pair;
	logic [a64pue_pkg::NUM_PHASES-1:0] present_c;

	always_comb begin
		chain   = (cr_q == a64pue_pkg::CR_CHAIN_SIGN) || (cr_q == a64pue_pkg::CR_CHAIN);
		lr_pair = (cr_q == a64pue_pkg::CR_LR_SAVED) && regi_q[0];
		present_c = '0;
		present_c[a64pue_pkg::PH_SIGN]   = (cr_q == a64pue_pkg::CR_CHAIN_SIGN);
		present_c[a64pue_pkg::PH_INT]    = (regi_q != 4'd0);
		present_c[a64pue_pkg::PH_LR]     = (cr_q == a64pue_pkg::CR_LR_SAVED) && !lr_pair;
		present_c[a64pue_pkg::PH_FP]     = (regf_q != 3'd0);
		present_c[a64pue_pkg::PH_HOME]   = home_q;
		present_c[a64pue_pkg::PH_ALLOC1] = chain ? (local_q > a64pue_pkg::CHAIN_PAIR_LIMIT)
			: (local_q != 13'd0);
		present_c[a64pue_pkg::PH_ALLOC2] = (local_q > a64pue_pkg::MAX_SINGLE_ALLOC);
		present_c[a64pue_pkg::PH_FPLR]   = chain;
		present_c[a64pue_pkg::PH_SETFP]  = chain;
	end

	// Loop position within the current phase, and run position
	logic [4:0] idx_q;
	logic [4:0] opidx_q;

	// Save loop terms
	logic [4:0]  regi5;
	logic [4:0]  nfp5;
	logic        int_first;
	logic        int_lastr;
	logic        int_paired;
	logic [5:0]  int_r1;
	logic        fp_carries;
	logic        fp_first;
	logic        fp_lastr;
	logic        fp_lead;
	logic [5:0]  fp_r1;
	logic [12:0] saved13;
	logic [12:0] idx_x8;

	always_comb begin
		regi5      = {1'b0, regi_q};
		nfp5       = {2'b00, regf_q} + 5'd1;
		int_first  = (idx_q == 5'd0);
		int_lastr  = ((idx_q + 5'd1) == regi5);
		int_paired = !int_lastr || lr_pair;
		int_r1     = a64pue_pkg::REG_FIRST_INT + {1'b0, idx_q};
		fp_carries = (regi_q == 4'd0) && (cr_q != a64pue_pkg::CR_LR_SAVED) && (regf_q != 3'd0);
		fp_first   = (idx_q == 5'd0);
		fp_lastr   = ((idx_q + 5'd1) == nfp5);
		fp_lead    = fp_first && fp_carries;
		fp_r1      = a64pue_pkg::REG_FIRST_FP + {1'b0, idx_q};
		saved13    = {4'b0000, saved_q};
		idx_x8     = {5'b00000, idx_q, 3'b000};
	end

	// Fields of the current step
	logic [2:0]  s_kind;
	logic        s_class;
	logic [5:0]  s_r1;
	logic [5:0]  s_r2;
	logic [12:0] s_off;
	logic [1:0]  s_status;
	logic        s_done;

	always_comb begin
		s_kind  = a64pue_pkg::OP_NONE;
		s_class = a64pue_pkg::CLASS_GP;
		s_r1    = 6'd0;
		s_r2    = 6'd0;
		s_off   = 13'd0;
		s_done  = 1'b1;
		if (mal_q)
			s_status = a64pue_pkg::ST_MALFORMED;
		else if (regf_q == 3'd1)
			s_status = a64pue_pkg::ST_PARTIAL;
		else
			s_status = a64pue_pkg::ST_OK;
		unique case (cmd.phase)
			a64pue_pkg::PH_SIGN: begin
				s_kind = a64pue_pkg::OP_SIGN_RA;
				s_r1   = a64pue_pkg::REG_LR;
			end
			a64pue_pkg::PH_INT: begin
				if (int_first)
					s_kind = int_paired ? a64pue_pkg::OP_SAVE_PAIR_PRE
						: a64pue_pkg::OP_SAVE_REG_PRE;
				else
					s_kind = int_paired ? a64pue_pkg::OP_SAVE_PAIR : a64pue_pkg::OP_SAVE_REG;
				s_r1   = int_r1;
				s_r2   = int_paired ? (int_lastr ? a64pue_pkg::REG_LR : int_r1 + 6'd1) : 6'd0;
				s_off  = int_first ? saved13 : idx_x8;
				s_done = ((idx_q + 5'd2) >= regi5);
			end
			a64pue_pkg::PH_LR: begin
				s_r1 = a64pue_pkg::REG_LR;
				if (regi_q == 4'd0) begin
					s_kind = a64pue_pkg::OP_SAVE_REG_PRE;
					s_off  = saved13;
				end else begin
					s_kind = a64pue_pkg::OP_SAVE_REG;
					s_off  = {5'b00000, int_bytes_q} - 13'd8;
				end
			end
			a64pue_pkg::PH_FP: begin
				if (fp_lead)
					s_kind = fp_lastr ? a64pue_pkg::OP_SAVE_REG_PRE
						: a64pue_pkg::OP_SAVE_PAIR_PRE;
				else
					s_kind = fp_lastr ? a64pue_pkg::OP_SAVE_REG : a64pue_pkg::OP_SAVE_PAIR;
				s_class = a64pue_pkg::CLASS_FP;
				s_r1    = fp_r1;
				s_r2    = fp_lastr ? 6'd0 : fp_r1 + 6'd1;
				s_off   = fp_lead ? saved13 : ({5'b00000, int_bytes_q} + idx_x8);
				s_done  = ((idx_q + 5'd2) >= nfp5);
			end
			a64pue_pkg::PH_HOME: begin
				s_kind = a64pue_pkg::OP_SAVE_PAIR;
				s_r1   = {3'b000, idx_q[1:0], 1'b0};
				s_r2   = {3'b000, idx_q[1:0], 1'b1};
				s_off  = {5'b00000, int_bytes_q} + {6'b000000, fp_bytes_q}
					+ {4'b0000, idx_q, 4'b0000};
				s_done = (idx_q[1:0] == 2'd3);
			end
			a64pue_pkg::PH_ALLOC1: begin
				s_kind = a64pue_pkg::OP_ALLOC;
				s_off  = (local_q > a64pue_pkg::MAX_SINGLE_ALLOC) ? a64pue_pkg::MAX_SINGLE_ALLOC
					: local_q;
			end
			a64pue_pkg::PH_ALLOC2: begin
				s_kind = a64pue_pkg::OP_ALLOC;
				s_off  = local_q - a64pue_pkg::MAX_SINGLE_ALLOC;
			end
			a64pue_pkg::PH_FPLR: begin
				s_r1 = a64pue_pkg::REG_FP;
				s_r2 = a64pue_pkg::REG_LR;
				if (local_q <= a64pue_pkg::CHAIN_PAIR_LIMIT) begin
					s_kind = a64pue_pkg::OP_SAVE_PAIR_PRE;
					s_off  = local_q;
				end else begin
					s_kind = a64pue_pkg::OP_SAVE_PAIR;
				end
			end
			a64pue_pkg::PH_SETFP: begin
				s_kind = a64pue_pkg::OP_SET_FP;
				s_r1   = a64pue_pkg::REG_FP;
			end
			a64pue_pkg::PH_MAL: begin
				s_status = a64pue_pkg::ST_MALFORMED;
			end
			default: begin
				s_done = 1'b1;
			end
		endcase
	end

	// Status to the controller
	assign stat = '{present: present_c, mal: mal_q, done: s_done};

	// Loop and run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 5'd0;
			opidx_q <= 5'd0;
		end else if (cmd.load) begin
			idx_q   <= 5'd0;
			opidx_q <= 5'd0;
		end else if (cmd.emit) begin
			opidx_q <= opidx_q + 5'd1;
			if (s_done)
				idx_q <= 5'd0;
			else if (cmd.phase == a64pue_pkg::PH_HOME)
				idx_q <= idx_q + 5'd1;
			else
				idx_q <= idx_q + 5'd2;
		end
	end

	// Result register
	logic [2:0]  kind_q;
	logic        class_q;
	logic [5:0]  r1_q;
	logic [5:0]  r2_q;
	logic [12:0] off_q;
	logic [4:0]  index_q;
	logic [1:0]  status_q;
	logic        last_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= s_kind;
			class_q  <= s_class;
			r1_q     <= s_r1;
			r2_q     <= s_r2;
			off_q    <= s_off;
			index_q  <= opidx_q;
			status_q <= s_status;
			last_q   <= cmd.last;
		end
	end

	assign op_kind      = kind_q;
	assign reg_class    = class_q;
	assign first_reg    = r1_q;
	assign second_reg   = r2_q;
	assign stack_offset = off_q;
	assign op_index     = index_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

>>> hdl/a64pue_ctrl.sv
module a64pue_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  a64pue_pkg::dp_stat_t stat,
	output a64pue_pkg::dp_cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_DEC    = 12'b0000_0000_0010,
		S_MAL    = 12'b0000_0000_0100,
		S_SIGN   = 12'b0000_0000_1000,
		S_INT    = 12'b0000_0001_0000,
		S_LR     = 12'b0000_0010_0000,
		S_FP     = 12'b0000_0100_0000,
		S_HOME   = 12'b0000_1000_0000,
		S_ALLOC1 = 12'b0001_0000_0000,
		S_ALLOC2 = 12'b0010_0000_0000,
		S_FPLR   = 12'b0100_0000_0000,
		S_SETFP  = 12'b1000_0000_0000
	} state_t;

	// First phase still to come, or idle when none is left
	function automatic state_t first_state(input logic [a64pue_pkg::NUM_PHASES-1:0] p);
		state_t s;
		priority if (p[a64pue_pkg::PH_SIGN])   s = S_SIGN;
		else if (p[a64pue_pkg::PH_INT])        s = S_INT;
		else if (p[a64pue_pkg::PH_LR])         s = S_LR;
		else if (p[a64pue_pkg::PH_FP])         s = S_FP;
		else if (p[a64pue_pkg::PH_HOME])       s = S_HOME;
		else if (p[a64pue_pkg::PH_ALLOC1])     s = S_ALLOC1;
		else if (p[a64pue_pkg::PH_ALLOC2])     s = S_ALLOC2;
		else if (p[a64pue_pkg::PH_FPLR])       s = S_FPLR;
		else if (p[a64pue_pkg::PH_SETFP])      s = S_SETFP;
		else                                   s = S_IDLE;
		return s;
	endfunction

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   adv;
	logic   emitting;
	logic [a64pue_pkg::NUM_PHASES-1:0] rest;
	a64pue_pkg::phase_t phase;

	// Phase driven to the datapath in each state
	always_comb begin
		emitting = 1'b1;
		unique case (state_q)
			S_IDLE:   begin phase = a64pue_pkg::PH_MAL; emitting = 1'b0; end
			S_DEC:    begin phase = a64pue_pkg::PH_MAL; emitting = 1'b0; end
			S_MAL:    phase = a64pue_pkg::PH_MAL;
			S_SIGN:   phase = a64pue_pkg::PH_SIGN;
			S_INT:    phase = a64pue_pkg::PH_INT;
			S_LR:     phase = a64pue_pkg::PH_LR;
			S_FP:     phase = a64pue_pkg::PH_FP;
			S_HOME:   phase = a64pue_pkg::PH_HOME;
			S_ALLOC1: phase = a64pue_pkg::PH_ALLOC1;
			S_ALLOC2: phase = a64pue_pkg::PH_ALLOC2;
			S_FPLR:   phase = a64pue_pkg::PH_FPLR;
			S_SETFP:  phase = a64pue_pkg::PH_SETFP;
			default:  begin phase = a64pue_pkg::PH_MAL; emitting = 1'b0; end
		endcase
	end

	// Phases after the current one that still produce results
	always_comb begin
		if (state_q == S_DEC)
			rest = stat.present;
		else
			rest = stat.present & ({a64pue_pkg::NUM_PHASES{1'b1}} << (phase + 4'd1));
	end

	assign adv = !out_valid_q || !out_stall;

	// Commands and next state
	always_comb begin
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.emit  = emitting && adv;
		cmd.phase = phase;
		cmd.last  = stat.done && (rest == '0);
		state_d   = state_q;
		if (state_q == S_IDLE) begin
			if (in_valid)
				state_d = S_DEC;
		end else if (state_q == S_DEC) begin
			state_d = stat.mal ? S_MAL : first_state(rest);
		end else if (cmd.emit && stat.done) begin
			state_d = first_state(rest);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hdl/arm64_packed_unwind_expander_core.sv
// Expands one ARM64 packed unwind word into its run of prologue operations,
// one result transaction per operation, in prologue order, with last set on
// the final one; a word that is not packed or whose saves overrun its frame
// gives a single malformed result, and a word with nothing to describe gives
// none. Words are handled one at a time: a taken word is first decoded into
// the decode registers, then one result per cycle goes into the output
// register while it is not stalled, and the next word is taken the cycle
// after the last result is loaded. The longest run is 21 results. The
// sequencer state machine steps through the phases.
module arm64_packed_unwind_expander_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] packed_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  op_kind,
	output logic        reg_class,
	output logic [5:0]  first_reg,
	output logic [5:0]  second_reg,
	output logic [12:0] stack_offset,
	output logic [4:0]  op_index,
	output logic [1:0]  status,
	output logic        last
);

	a64pue_pkg::dp_cmd_t  cmd;
	a64pue_pkg::dp_stat_t stat;

	// Sequencer
	a64pue_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Decode and field generation
	a64pue_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.packed_word  (packed_word),
		.cmd          (cmd),
		.stat         (stat),
		.op_kind      (op_kind),
		.reg_class    (reg_class),
		.first_reg    (first_reg),
		.second_reg   (second_reg),
		.stack_offset (stack_offset),
		.op_index     (op_index),
		.status       (status),
		.last         (last)
	);

`ifndef SYNTHESIS
	// A malformed word yields exactly one result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == a64pue_pkg::ST_MALFORMED)) |->
		(last && (op_index == 5'd0) && (op_kind == a64pue_pkg::OP_NONE)))
		else $error("malformed result not a lone terminal result");

	// A taken word holds off the next one while it is decoded
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again straight after a word");

	// No run is longer than the longest prologue
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (op_index <= 5'd21))
		else $error("run index out of range");

	// Return-address signing only ever opens a run
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (op_kind == a64pue_pkg::OP_SIGN_RA)) |-> (op_index == 5'd0))
		else $error("signing step not first in run");
`endif

endmodule
